// ----- design/itavg_pkg.sv -----
package itavg_pkg;

	localparam int NUM_CHANNELS  = 9;
	localparam int BLOCK_SAMPLES = 8;
	localparam int COUNT_WIDTH   = 16;

	localparam int SAMPLE_W = 12;
	localparam int CHAN_W   = 4;
	localparam int FRAME_W  = 18;
	localparam int LONG_W   = 28;

	localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SCAN_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

	// Frame average is taken as a multiply by a rounded-up reciprocal of the block size.
	localparam int RECIP_SHIFT = FRAME_W + 7;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = FRAME_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES));

	localparam logic [LONG_W-1:0]      LONG_MAX  = {LONG_W{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic REQ_SAMPLE  = 1'b0;
	localparam logic REQ_READOUT = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] average;
		logic                no_data;
		logic                saturated;
		logic                last;
	} res_t;

	typedef struct packed {
		logic                readout;
		logic [SAMPLE_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic                   start;
		logic [LONG_W-1:0]      dividend;
		logic [COUNT_WIDTH-1:0] divisor;
	} div_req_t;

endpackage

// ----- design/itavg_front.sv -----
module itavg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  itavg_pkg::req_t  req,
	output logic             cmd_valid,
	output itavg_pkg::cmd_t  cmd,
	input  logic             cmd_pop
);
	import itavg_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{readout: (req.req_type == REQ_READOUT), sample: req.sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/itavg_div.sv -----
module itavg_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  itavg_pkg::div_req_t                  dreq,
	output logic                                 done,
	output logic [itavg_pkg::LONG_W-1:0]         quotient
);
	import itavg_pkg::*;

	localparam int CNT_W = $clog2(LONG_W + 1);

	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] dsr_q;
	logic [LONG_W-1:0]      quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [COUNT_WIDTH:0]   shifted;
	logic [COUNT_WIDTH:0]   diff;
	logic                   fits;

	assign shifted  = {rem_q, quo_q[LONG_W-1]};
	assign fits     = (shifted >= {1'b0, dsr_q});
	assign diff     = shifted - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			rem_q <= '0;
			dsr_q <= dreq.divisor;
			quo_q <= dreq.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
			quo_q <= {quo_q[LONG_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(LONG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/itavg_back.sv -----
module itavg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  itavg_pkg::cmd_t              cmd,
	output logic                         cmd_pop,
	output itavg_pkg::div_req_t          dreq,
	input  logic                         div_done,
	input  logic [itavg_pkg::LONG_W-1:0] div_quotient,
	output logic                         res_valid,
	input  logic                         res_ready,
	output itavg_pkg::res_t              res
);
	import itavg_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CMUL   = 3'd1;
	localparam logic [2:0] ST_CADD   = 3'd2;
	localparam logic [2:0] ST_RSTART = 3'd3;
	localparam logic [2:0] ST_RWAIT  = 3'd4;
	localparam logic [2:0] ST_REMIT  = 3'd5;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       scan_ch_q;
	logic [SCAN_W-1:0]      scan_idx_q;
	logic [FRAME_W-1:0]     frame_q [NUM_CHANNELS];
	logic [LONG_W-1:0]      long_q [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   ovf_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SAMPLE_W-1:0]    avg_q;
	logic                   res_valid_q;
	res_t                   res_q;

	logic [IDX_W-1:0]   fs_addr;
	logic [FRAME_W-1:0] fs_rd;
	logic [LONG_W-1:0]  ls_rd;
	logic [FRAME_W-1:0] frame_avg;
	logic [LONG_W:0]    long_add;
	logic [LONG_W-1:0]  long_sat;
	logic               keep;
	logic               last_ch;
	logic               scan_wrap;
	logic               frame_end;
	logic               res_free;

	assign fs_addr   = (state_q == ST_IDLE) ? scan_ch_q : idx_q;
	assign fs_rd     = frame_q[fs_addr];
	assign ls_rd     = long_q[idx_q];
	assign frame_avg = prod_q[RECIP_SHIFT +: FRAME_W];
	assign long_add  = {1'b0, ls_rd} + (LONG_W + 1)'(frame_avg);
	assign long_sat  = long_add[LONG_W] ? LONG_MAX : long_add[LONG_W-1:0];
	assign keep      = (count_q != COUNT_MAX);
	assign last_ch   = (idx_q == IDX_W'(NUM_CHANNELS - 1));
	assign scan_wrap = (scan_ch_q == IDX_W'(NUM_CHANNELS - 1));
	assign frame_end = scan_wrap && (scan_idx_q == SCAN_W'(BLOCK_SAMPLES - 1));
	assign res_free  = !res_valid_q || res_ready;

	assign cmd_pop       = (state_q == ST_IDLE) && cmd_valid;
	assign dreq.start    = (state_q == ST_RSTART) && (count_q != '0);
	assign dreq.dividend = ls_rd;
	assign dreq.divisor  = count_q;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CMUL) begin
			prod_q <= PROD_W'(fs_rd) * PROD_W'(RECIP);
		end
		if ((state_q == ST_RSTART) && (count_q == '0)) begin
			avg_q <= '0;
		end else if ((state_q == ST_RWAIT) && div_done) begin
			avg_q <= div_quotient[SAMPLE_W-1:0];
		end
		if ((state_q == ST_REMIT) && res_free) begin
			res_q <= '{channel:   CHAN_W'(idx_q),
			           average:   avg_q,
			           no_data:   (count_q == '0),
			           saturated: ovf_q,
			           last:      last_ch};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			scan_ch_q   <= '0;
			scan_idx_q  <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				frame_q[i] <= '0;
				long_q[i]  <= '0;
			end
		end else begin
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q <= '0;
						if (cmd.readout) begin
							state_q <= ST_RSTART;
						end else begin
							frame_q[scan_ch_q] <= fs_rd + FRAME_W'(cmd.sample);
							if (scan_wrap) begin
								scan_ch_q <= '0;
								if (frame_end) begin
									scan_idx_q <= '0;
									state_q    <= ST_CMUL;
								end else begin
									scan_idx_q <= scan_idx_q + SCAN_W'(1);
								end
							end else begin
								scan_ch_q <= scan_ch_q + IDX_W'(1);
							end
						end
					end
				end
				ST_CMUL: begin
					frame_q[idx_q] <= '0;
					state_q        <= ST_CADD;
				end
				ST_CADD: begin
					if (keep) begin
						long_q[idx_q] <= long_sat;
					end
					if (last_ch) begin
						if (keep) begin
							count_q <= count_q + COUNT_WIDTH'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_CMUL;
					end
				end
				ST_RSTART: begin
					state_q <= (count_q == '0) ? ST_REMIT : ST_RWAIT;
				end
				ST_RWAIT: begin
					if (div_done) begin
						state_q <= ST_REMIT;
					end
				end
				ST_REMIT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (last_ch) begin
							for (int i = 0; i < NUM_CHANNELS; i++) begin
								long_q[i] <= '0;
							end
							count_q <= '0;
							ovf_q   <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_RSTART;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/interleaved_adc_two_stage_averager_top.sv -----
// A sample is registered in the input queue and updates its frame sum at the head of the queue.
// Throughput is one sample per cycle while the back end is idle; closing a frame steps through
// a multiply and an add state per channel. A readout runs, per channel, the one-bit-per-cycle
// divider over 28 bits, or skips it with no completed frame; results leave via the output register.
// The asynchronous active-low reset clears the scan position, all sums, the count and the flag.
module interleaved_adc_two_stage_averager_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  itavg_pkg::req_t req,
	output logic            res_valid,
	input  logic            res_ready,
	output itavg_pkg::res_t res
);
	import itavg_pkg::*;

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	div_req_t          dreq;
	logic              div_done;
	logic [LONG_W-1:0] div_quotient;

	itavg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	itavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.dreq     (dreq),
		.done     (div_done),
		.quotient (div_quotient)
	);

	itavg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.dreq         (dreq),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

endmodule

// ----- design/itavg_checker.sv -----
module itavg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input itavg_pkg::res_t res
);
	import itavg_pkg::*;

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A result with no completed frame carries a zero average.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.no_data |-> res.average == '0)
		else $error("nonzero average without data");

	// Only the final channel of a readout is marked last.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == (res.channel == CHAN_W'(NUM_CHANNELS - 1))))
		else $error("last flag does not match channel");

	// After a non-final result transfer, the next result offered is the following channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res.last ##1 res_valid
		|-> res.channel == $past(res.channel) + CHAN_W'(1))
		else $error("channel sequence broken");

endmodule

bind interleaved_adc_two_stage_averager_top itavg_checker u_itavg_checker (.*);

// ----- verif/interleaved_adc_two_stage_averager_top_tb.sv -----
`timescale 1ns / 100ps

module interleaved_adc_two_stage_averager_top_tb;

	import itavg_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 6;
	localparam int TARGET_ITEMS = 500;
	localparam int HOLD_CYCLES  = 700;
	localparam int DRAIN_CYCLES = 400;
	localparam int MAX_REPORTS  = 50;

	typedef struct packed {
		req_t item;
		logic drain;
	} pending_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;

	pending_t pending_q[$];
	res_t     averages_expected[$];

	int  n_accepted  = 0;
	int  n_items     = 0;
	int  n_readouts  = 0;
	int  burst_start = -1;
	int  errors      = 0;
	bit  req_taken   = 0;
	bit  hold_off    = 0;
	int  gap_cnt     = 0;
	int  phase_cnt   = 0;
	bit  phase_ready = 1;

	logic [CHAN_W-1:0]      scan_chan;
	logic [5:0]             scan_pos;
	logic [FRAME_W-1:0]     frame_acc [NUM_CHANNELS];
	logic [LONG_W-1:0]      long_acc [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] frames_done;
	logic                   frames_dropped;

	interleaved_adc_two_stage_averager_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic clear_averager();
		scan_chan      = '0;
		scan_pos       = '0;
		frames_done    = '0;
		frames_dropped = 1'b0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			frame_acc[ch] = '0;
			long_acc[ch]  = '0;
		end
	endtask

	task automatic step_averager(input req_t it);
		res_t            r;
		logic [LONG_W:0] s;
		if (it.req_type == REQ_SAMPLE) begin
			frame_acc[scan_chan] = FRAME_W'(frame_acc[scan_chan] + it.sample);
			scan_chan = scan_chan + 1'b1;
			if (scan_chan >= NUM_CHANNELS) begin
				scan_chan = '0;
				scan_pos  = scan_pos + 1'b1;
				if (scan_pos >= BLOCK_SAMPLES) begin
					scan_pos = '0;
					for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
						if (frames_done != COUNT_MAX) begin
							s = {1'b0, long_acc[ch]}
								+ (LONG_W + 1)'(frame_acc[ch] / FRAME_W'(BLOCK_SAMPLES));
							long_acc[ch] = (s > LONG_MAX) ? LONG_MAX : s[LONG_W-1:0];
						end
						frame_acc[ch] = '0;
					end
					if (frames_done != COUNT_MAX)
						frames_done = frames_done + 1'b1;
					else
						frames_dropped = 1'b1;
				end
			end
		end else begin
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				r.channel   = CHAN_W'(ch);
				r.average   = (frames_done == 0) ? '0 : SAMPLE_W'(long_acc[ch] / frames_done);
				r.no_data   = (frames_done == 0);
				r.saturated = frames_dropped;
				r.last      = (ch == NUM_CHANNELS - 1);
				averages_expected.push_back(r);
			end
			for (int ch = 0; ch < NUM_CHANNELS; ch++)
				long_acc[ch] = '0;
			frames_done    = '0;
			frames_dropped = 1'b0;
		end
	endtask

	task automatic queue_item(input logic kind, input logic [SAMPLE_W-1:0] value, input bit drain);
		pending_t p;
		p.item.req_type = kind;
		p.item.sample   = value;
		p.drain         = drain;
		pending_q.push_back(p);
		n_items++;
		if (kind == REQ_READOUT)
			n_readouts++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
		case (mode)
			0: pick_sample = SAMPLE_W'($urandom);
			1: pick_sample = '1;
			2: pick_sample = '0;
			default: pick_sample = ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				req_taken = 1;
				n_accepted++;
				step_averager(req);
			end
			if (res_valid && res_ready) begin
				if (averages_expected.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result ch=%0d avg=%0d nd=%0b sat=%0b last=%0b",
							$time, res.channel, res.average, res.no_data, res.saturated, res.last);
				end else begin
					if (res.channel !== averages_expected[0].channel
							|| res.average !== averages_expected[0].average
							|| res.no_data !== averages_expected[0].no_data
							|| res.saturated !== averages_expected[0].saturated
							|| res.last !== averages_expected[0].last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display({"%0t: expected ch=%0d avg=%0d nd=%0b sat=%0b last=%0b,",
								" actual ch=%0d avg=%0d nd=%0b sat=%0b last=%0b"}, $time,
								averages_expected[0].channel, averages_expected[0].average,
								averages_expected[0].no_data, averages_expected[0].saturated,
								averages_expected[0].last, res.channel, res.average,
								res.no_data, res.saturated, res.last);
					end
					void'(averages_expected.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		int r;
		if (arst_n && !(req_valid && !req_taken)) begin
			req_taken = 0;
			if (gap_cnt != 0) begin
				req_valid <= 1'b0;
				gap_cnt--;
			end else if (pending_q.size() != 0
					&& !(pending_q[0].drain && averages_expected.size() != 0)) begin
				req       <= pending_q[0].item;
				req_valid <= 1'b1;
				void'(pending_q.pop_front());
				r = $urandom_range(0, 99);
				if (r < 50)
					gap_cnt = 0;
				else if (r < 90)
					gap_cnt = $urandom_range(1, 3);
				else if (r < 98)
					gap_cnt = $urandom_range(4, 12);
				else
					gap_cnt = $urandom_range(30, 80);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int r;
		if (arst_n) begin
			if (phase_cnt == 0) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					phase_ready = 1;
					phase_cnt   = $urandom_range(1, 40);
				end else if (r < 90) begin
					phase_ready = 0;
					phase_cnt   = $urandom_range(1, 3);
				end else if (r < 98) begin
					phase_ready = 0;
					phase_cnt   = $urandom_range(4, 15);
				end else begin
					phase_ready = 0;
					phase_cnt   = $urandom_range(30, 80);
				end
			end
			phase_cnt--;
			res_ready <= phase_ready && !hold_off;
		end
	end

	// The output side stalls for a long stretch while a run of readouts is offered.
	initial begin
		wait (burst_start >= 0 && n_accepted >= burst_start);
		@(posedge clk);
		hold_off = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int nsamp;
		int mode;
		int pick;
		bit drain_next;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		res_ready = 1'b0;
		clear_averager();

		// Readouts with no completed frame, extremes of the sample, then a partial frame.
		queue_item(REQ_READOUT, '0, 0);
		queue_item(REQ_READOUT, '1, 0);
		queue_item(REQ_SAMPLE, '1, 0);
		queue_item(REQ_SAMPLE, '0, 0);
		queue_item(REQ_SAMPLE, 12'hAAA, 0);
		queue_item(REQ_SAMPLE, 12'h555, 0);
		queue_item(REQ_SAMPLE, '1, 0);
		queue_item(REQ_SAMPLE, 12'h001, 0);
		queue_item(REQ_SAMPLE, 12'h800, 0);
		queue_item(REQ_READOUT, 12'h5A5, 0);

		drain_next = 1;
		while (n_items < TARGET_ITEMS || n_readouts < 12) begin
			if (burst_start < 0 && n_items >= 150) begin
				burst_start = n_items;
				for (int k = 0; k < 12; k++) begin
					queue_item(REQ_READOUT, SAMPLE_W'($urandom), 0);
					repeat ($urandom_range(0, 3))
						queue_item(REQ_SAMPLE, SAMPLE_W'($urandom), 0);
				end
				drain_next = 1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 50)
				nsamp = $urandom_range(72, 160);
			else if (pick < 80)
				nsamp = $urandom_range(0, 30);
			else
				nsamp = $urandom_range(0, 250);
			mode = $urandom_range(0, 3);
			for (int i = 0; i < nsamp; i++) begin
				queue_item(REQ_SAMPLE, pick_sample(mode), drain_next);
				drain_next = 0;
			end
			queue_item(REQ_READOUT, SAMPLE_W'($urandom), drain_next);
			drain_next = 0;
			if ($urandom_range(0, 99) < 15)
				queue_item(REQ_READOUT, SAMPLE_W'($urandom), 0);
			if ($urandom_range(0, 99) < 10)
				drain_next = 1;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_q.size() == 0 && !req_valid);
		wait (averages_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (averages_expected.size() != 0)
			errors++;
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/itavg_pkg.sv
design/itavg_front.sv
design/itavg_div.sv
design/itavg_back.sv
design/interleaved_adc_two_stage_averager_top.sv
design/itavg_checker.sv
verif/interleaved_adc_two_stage_averager_top_tb.sv
